>>> rtl/core/ccp_pkg.sv
package ccp_pkg;

  localparam int unsigned MODULUS = 3329;

  // Field and state widths.
  localparam int unsigned VAL_W  = 12;
  localparam int unsigned D_W    = 4;
  localparam int unsigned CODE_W = 11;
  localparam int unsigned ACC_W  = 18;
  localparam int unsigned CNT_W  = 5;
  // A 12-bit coefficient shifted by up to 11 bits, plus half the modulus.
  localparam int unsigned NUM_W  = 23;

  localparam logic [D_W-1:0] D_RESET = 4'd4;
  localparam logic [D_W-1:0] D_MIN   = 4'd1;
  localparam logic [D_W-1:0] D_MAX   = 4'd11;

  // floor(2^32 / MODULUS); the quotient estimate is low by at most one.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / MODULUS);
  localparam logic [NUM_W-1:0] HALF_MOD = NUM_W'(MODULUS / 2);

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic OP_COMPRESS   = 1'b0;
  localparam logic OP_DECOMPRESS = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_COEFF = 1'b1;

  // One classified item: a d-bit compressed code or a packed byte.
  typedef struct packed {
    logic              op;
    logic              eop;
    logic [CODE_W-1:0] code;
  } item_t;

endpackage

>>> rtl/core/ccp_front.sv
module ccp_front #(
  parameter int unsigned DEPTH = ccp_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_op_i,
  input  logic [ccp_pkg::VAL_W-1:0]       in_val_i,
  input  logic                            in_eop_i,
  input  logic [ccp_pkg::D_W-1:0]         d_i,
  input  logic [$clog2(DEPTH+1)-1:0]      fifo_count_i,
  output logic                            push_o,
  output ccp_pkg::item_t                  push_item_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = ccp_pkg::NUM_W;

  logic                 s1_v_q, s1_v_d;
  logic                 s1_op_q, s1_eop_q;
  logic [NW-1:0]        s1_num_q, s1_num_d;
  logic                 s2_v_q;
  logic                 s2_op_q, s2_eop_q;
  logic [NW-1:0]        s2_num_q;
  logic [NW-1:0]        s2_q0_q, s2_q0_d;
  logic [NW+31:0]       prod;
  logic [NW-1:0]        chk;
  logic [NW-1:0]        rem;
  logic [NW-1:0]        quot;
  logic [ccp_pkg::CODE_W-1:0] mask;
  logic [CW:0]          used;
  logic                 accept;

  // Items in flight in the pipeline hold a slot in the queue in advance.
  assign used = (CW+1)'(fifo_count_i) + (CW+1)'(s1_v_q) + (CW+1)'(s2_v_q);
  assign in_ready_o = used < (CW+1)'(DEPTH);
  assign accept = in_valid_i && in_ready_o;
  assign s1_v_d = accept;

  always_comb begin
    if (in_op_i == ccp_pkg::OP_DECOMPRESS) begin
      s1_num_d = NW'(in_val_i[7:0]);
    end else begin
      s1_num_d = (NW'(in_val_i) << d_i) + ccp_pkg::HALF_MOD;
    end
  end

  assign prod = (NW+32)'(s1_num_q) * (NW+32)'(ccp_pkg::RECIP);
  assign s2_q0_d = prod[NW+31:32];

  assign chk  = NW'(s2_q0_q * NW'(ccp_pkg::MODULUS));
  assign rem  = s2_num_q - chk;
  assign quot = s2_q0_q + NW'(rem >= NW'(ccp_pkg::MODULUS));
  assign mask = ccp_pkg::CODE_W'((12'd1 << d_i) - 12'd1);

  always_comb begin
    push_o = s2_v_q;
    push_item_o.op  = s2_op_q;
    push_item_o.eop = s2_eop_q;
    if (s2_op_q == ccp_pkg::OP_DECOMPRESS) begin
      push_item_o.code = ccp_pkg::CODE_W'(s2_num_q[7:0]);
    end else begin
      push_item_o.code = ccp_pkg::CODE_W'(quot) & mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q  <= in_op_i;
    s1_eop_q <= in_eop_i;
    s1_num_q <= s1_num_d;
    s2_op_q  <= s1_op_q;
    s2_eop_q <= s1_eop_q;
    s2_num_q <= s1_num_q;
    s2_q0_q  <= s2_q0_d;
  end

endmodule

>>> rtl/core/ccp_queue.sv
module ccp_queue #(
  parameter int unsigned DEPTH = ccp_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ccp_pkg::item_t             item_i,
  input  logic                       pop_i,
  output ccp_pkg::item_t             item_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ccp_pkg::item_t   mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign valid_o = count_q != '0;
  assign count_o = count_q;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && (count_q != CW'(DEPTH));
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/ccp_back.sv
module ccp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ccp_pkg::D_W-1:0]       d_i,
  input  logic                          cfg_clear_i,
  input  ccp_pkg::item_t                item_i,
  input  logic                          item_valid_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [ccp_pkg::VAL_W-1:0]     out_value_o,
  output logic                          out_last_o
);

  localparam int unsigned AW = ccp_pkg::ACC_W;
  localparam int unsigned CNW = ccp_pkg::CNT_W;

  logic [AW-1:0]  acc_q, acc_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           dir_q, dir_d;
  logic           active_q, active_d;
  logic           act_op_q, act_op_d;
  logic           act_eop_q, act_eop_d;
  logic           out_valid_q, out_valid_d;
  logic           out_kind_q, out_last_q;
  logic [ccp_pkg::VAL_W-1:0] out_value_q;

  logic [AW-1:0]  base_acc, src_acc, rem_acc;
  logic [CNW-1:0] base_cnt, src_cnt, rem_cnt, grp, act_grp;
  logic           src_op, src_eop, work, has, last, slot_free, load_out;
  logic [ccp_pkg::CODE_W-1:0] mask, sym;
  logic [23:0]    coef_sum;
  logic [ccp_pkg::VAL_W-1:0] res_value;

  // Merge the queue head into the pending bits; a change of direction
  // starts from an empty accumulator.
  always_comb begin
    if (item_i.op != dir_q) begin
      base_acc = '0;
      base_cnt = '0;
    end else begin
      base_acc = acc_q;
      base_cnt = cnt_q;
    end
    if (active_q) begin
      src_acc = acc_q;
      src_cnt = cnt_q;
      src_op  = act_op_q;
      src_eop = act_eop_q;
    end else begin
      src_acc = base_acc | (AW'(item_i.code) << base_cnt);
      src_cnt = base_cnt + ((item_i.op == ccp_pkg::OP_DECOMPRESS) ? CNW'(8) : CNW'(d_i));
      src_op  = item_i.op;
      src_eop = item_i.eop;
    end
  end

  assign grp  = (src_op == ccp_pkg::OP_DECOMPRESS) ? CNW'(d_i) : CNW'(8);
  assign has  = src_cnt >= grp;
  assign rem_cnt = src_cnt - grp;
  assign rem_acc = (src_op == ccp_pkg::OP_DECOMPRESS) ? (src_acc >> d_i) : (src_acc >> 8);
  assign last = rem_cnt < grp;

  assign mask = ccp_pkg::CODE_W'((12'd1 << d_i) - 12'd1);
  assign sym  = src_acc[ccp_pkg::CODE_W-1:0] & mask;
  assign coef_sum = 24'(sym) * 24'(ccp_pkg::MODULUS) + (24'd1 << (d_i - ccp_pkg::D_W'(1)));

  always_comb begin
    if (src_op == ccp_pkg::OP_DECOMPRESS) begin
      res_value = ccp_pkg::VAL_W'(coef_sum >> d_i);
    end else begin
      res_value = ccp_pkg::VAL_W'(src_acc[7:0]);
    end
  end

  assign work      = active_q || item_valid_i;
  assign slot_free = !out_valid_q || out_ready_i;
  assign load_out  = work && has && slot_free;

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    dir_d     = dir_q;
    active_d  = active_q;
    act_op_d  = act_op_q;
    act_eop_d = act_eop_q;
    pop_o     = 1'b0;
    if (work && !has) begin
      // An item that yields no result retires at once.
      pop_o = 1'b1;
      dir_d = src_op;
      acc_d = src_eop ? '0 : src_acc;
      cnt_d = src_eop ? '0 : src_cnt;
    end else if (load_out) begin
      pop_o     = !active_q;
      dir_d     = src_op;
      act_op_d  = src_op;
      act_eop_d = src_eop;
      active_d  = !last;
      if (last && src_eop) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = rem_acc;
        cnt_d = rem_cnt;
      end
    end
    if (cfg_clear_i) begin
      acc_d    = '0;
      cnt_d    = '0;
      active_d = 1'b0;
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      dir_q       <= ccp_pkg::OP_COMPRESS;
      active_q    <= 1'b0;
      act_op_q    <= ccp_pkg::OP_COMPRESS;
      act_eop_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      dir_q       <= dir_d;
      active_q    <= active_d;
      act_op_q    <= act_op_d;
      act_eop_q   <= act_eop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q  <= (src_op == ccp_pkg::OP_DECOMPRESS) ? ccp_pkg::KIND_COEFF
                                                        : ccp_pkg::KIND_BYTE;
      out_value_q <= res_value;
      out_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  assign act_grp = (act_op_q == ccp_pkg::OP_DECOMPRESS) ? CNW'(d_i) : CNW'(8);

  // An item still being unpacked always has at least one more group pending.
  a_active_has_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> cnt_q >= act_grp)
    else $error("active item without a full group pending");

  // A result that is not the last of its item leaves the item in progress.
  a_not_last_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !last && !cfg_clear_i) |=> active_q)
    else $error("item retired before its last result");

  // Nothing is taken from the queue while an item is still being unpacked.
  a_no_pop_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !pop_o)
    else $error("queue popped during an active item");

endmodule

>>> rtl/core/coefficient_compress_pack.sv
// Coefficient compressor / decompressor with LSB-first bit packing. An item
// with tuser 0 carries a coefficient in tdata and produces
// round(2^d * x / q) mod 2^d, packed into bytes; tuser 1 carries one byte
// whose bits are cut into d-bit groups, each expanded to round(v * q / 2^d).
// Results carry tuser 0 for a byte and 1 for a coefficient, and tlast marks
// the final result of an input item; an item may give no result at all.
// The pending bits are dropped after an item with tlast set, when the
// direction changes, and on every write of d. An item passes the front end
// (two multiplies, registered in s1 and s2) into a four-entry queue; the
// back end emits one result per cycle through its output register unless
// the output is stalled. An item gives up to two bytes when compressing
// and up to eight coefficients when decompressing at d = 1. Back-to-back
// items are taken every cycle while the queue has room, counting s1 and s2.
module coefficient_compress_pack #(
  parameter int unsigned QUEUE_DEPTH = ccp_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,    // bit_width
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
  input  logic        s_axis_tuser,   // opcode
  input  logic        s_axis_tlast,   // end_of_poly
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] out_value, [15:12] zero
  output logic        m_axis_tuser,   // out_kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [ccp_pkg::D_W-1:0] cfg_q;
  logic [ccp_pkg::D_W-1:0] d_eff;
  logic                    push, pop, fifo_valid;
  logic [CW-1:0]           fifo_count;
  ccp_pkg::item_t          push_item, head_item;
  logic [ccp_pkg::VAL_W-1:0] out_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ccp_pkg::D_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q < ccp_pkg::D_MIN) begin
      d_eff = ccp_pkg::D_MIN;
    end else if (cfg_q > ccp_pkg::D_MAX) begin
      d_eff = ccp_pkg::D_MAX;
    end else begin
      d_eff = cfg_q;
    end
  end

  ccp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_val_i    (s_axis_tdata[11:0]),
    .in_eop_i    (s_axis_tlast),
    .d_i         (d_eff),
    .fifo_count_i(fifo_count),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ccp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .valid_o(fifo_valid),
    .count_o(fifo_count)
  );

  ccp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .d_i         (d_eff),
    .cfg_clear_i (cfg_we_i),
    .item_i      (head_item),
    .item_valid_i(fifo_valid),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_value};

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned QUIET_LIMIT  = 1000;

  typedef struct packed {
    logic        kind;
    logic [11:0] value;
    logic        last;
  } result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'd0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow copy of the packer state and the width register.
  logic [3:0]  width_shadow  = ccp_pkg::D_RESET;
  logic [17:0] pending_bits  = '0;
  logic [4:0]  pending_count = '0;
  logic        prev_op       = ccp_pkg::OP_COMPRESS;

  result_t     expected_results[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on  = 1'b1;
  bit          stall_on = 1'b1;

  coefficient_compress_pack u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the bytes or coefficients that one accepted item produces.
  function automatic void predict_packing(input logic op, input logic [11:0] val,
                                          input logic eop);
    int unsigned d;
    int unsigned acc;
    int unsigned cnt;
    int unsigned code;
    int unsigned n;
    result_t     res;
    if (width_shadow < ccp_pkg::D_MIN) d = ccp_pkg::D_MIN;
    else if (width_shadow > ccp_pkg::D_MAX) d = ccp_pkg::D_MAX;
    else d = width_shadow;
    if (op != prev_op) begin
      pending_bits  = '0;
      pending_count = '0;
      prev_op       = op;
    end
    acc = pending_bits;
    cnt = pending_count;
    n   = 0;
    if (op == ccp_pkg::OP_COMPRESS) begin
      code = (((32'(val) << d) + ccp_pkg::MODULUS / 2) / ccp_pkg::MODULUS) &
             ((1 << d) - 1);
      acc  = acc | (code << cnt);
      cnt  = cnt + d;
      while (cnt >= 8) begin
        res.kind  = ccp_pkg::KIND_BYTE;
        res.value = 12'(acc & 32'hff);
        res.last  = 1'b0;
        expected_results.push_back(res);
        acc = acc >> 8;
        cnt = cnt - 8;
        n++;
      end
    end else begin
      acc = acc | (32'(val[7:0]) << cnt);
      cnt = cnt + 8;
      while (cnt >= d && n < 8) begin
        code      = acc & ((1 << d) - 1);
        res.kind  = ccp_pkg::KIND_COEFF;
        res.value = 12'((code * ccp_pkg::MODULUS + (1 << (d - 1))) >> d);
        res.last  = 1'b0;
        expected_results.push_back(res);
        acc = acc >> d;
        cnt = cnt - d;
        n++;
      end
    end
    if (n > 0) expected_results[expected_results.size() - 1].last = 1'b1;
    pending_bits  = 18'(acc);
    pending_count = 5'(cnt);
    if (eop) begin
      pending_bits  = '0;
      pending_count = '0;
    end
  endfunction

  task automatic send_item(input logic op, input logic [11:0] val, input logic eop);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, val};
    s_axis_tuser  <= op;
    s_axis_tlast  <= eop;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_packing(op, val, eop);
  endtask

  // The block must be idle: no item in flight, and time for zero-result items to drain.
  task automatic set_width(input logic [3:0] w);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    width_shadow  = w;
    pending_bits  = '0;
    pending_count = '0;
  endtask

  task automatic test_reset_width();
    send_item(ccp_pkg::OP_COMPRESS, 12'd0, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd4095, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd3328, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd1664, 1'b1);
    send_item(ccp_pkg::OP_DECOMPRESS, 12'h0ff, 1'b0);
    // Only the low byte of value counts when decompressing.
    send_item(ccp_pkg::OP_DECOMPRESS, 12'ha5c, 1'b1);
    // Each change of direction drops the pending bits.
    send_item(ccp_pkg::OP_COMPRESS, 12'd100, 1'b0);
    send_item(ccp_pkg::OP_DECOMPRESS, 12'h03c, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd200, 1'b1);
  endtask

  task automatic test_width_extremes();
    set_width(4'd1);
    send_item(ccp_pkg::OP_COMPRESS, 12'd0, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd1664, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd3328, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd4095, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd832, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd833, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd2496, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd2497, 1'b1);
    send_item(ccp_pkg::OP_DECOMPRESS, 12'h0a5, 1'b1);
    set_width(4'd11);
    // Three codes give four bytes; the one bit left over is dropped at the end.
    send_item(ccp_pkg::OP_COMPRESS, 12'd4095, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd3328, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd1, 1'b1);
    send_item(ccp_pkg::OP_DECOMPRESS, 12'h0ff, 1'b0);
    send_item(ccp_pkg::OP_DECOMPRESS, 12'h00f, 1'b1);
    set_width(4'd0);
    send_item(ccp_pkg::OP_DECOMPRESS, 12'h081, 1'b1);
    set_width(4'd15);
    send_item(ccp_pkg::OP_COMPRESS, 12'd3328, 1'b0);
    send_item(ccp_pkg::OP_COMPRESS, 12'd1664, 1'b1);
  endtask

  task automatic send_random_run(input int unsigned run_len);
    int unsigned k;
    logic        run_op;
    logic        op;
    logic        eop;
    logic [11:0] val;
    run_op = 1'($urandom_range(0, 1));
    for (k = 0; k < run_len; k++) begin
      op = ($urandom_range(0, 9) == 0) ? ~run_op : run_op;
      if ($urandom_range(0, 7) == 0) val = 12'($urandom);
      else if (op == ccp_pkg::OP_COMPRESS) val = 12'($urandom_range(0, ccp_pkg::MODULUS - 1));
      else val = 12'($urandom_range(0, 255));
      if (k == run_len - 1) eop = ($urandom_range(0, 3) != 0);
      else eop = ($urandom_range(0, 15) == 0);
      send_item(op, val, eop);
    end
  endtask

  task automatic test_random_runs();
    int unsigned w;
    int unsigned sent;
    int unsigned run_len;
    for (w = 0; w < 16; w++) begin
      set_width(4'(w));
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 4) begin
        run_len = $urandom_range(1, 8);
        send_random_run(run_len);
        sent += run_len;
      end
    end
  endtask

  task automatic test_full_rate();
    int unsigned sent;
    int unsigned run_len;
    set_width(4'($urandom_range(ccp_pkg::D_MIN, ccp_pkg::D_MAX)));
    idle_on  = 1'b0;
    stall_on = 1'b0;
    sent = 0;
    while (sent < 24) begin
      run_len = $urandom_range(1, 8);
      send_random_run(run_len);
      sent += run_len;
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_on && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d value %0d last %0d",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (m_axis_tuser !== exp_res.kind || m_axis_tdata !== {4'b0000, exp_res.value} ||
            m_axis_tlast !== exp_res.last) begin
          $display({"%0t: mismatch: expected kind %0d value %0d last %0d, ",
                    "actual kind %0d value %0d last %0d"},
                   $time, exp_res.kind, exp_res.value, exp_res.last,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("status: fail");
        $finish;
      end
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_width();
    test_width_extremes();
    test_random_runs();
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ccp_pkg.sv
rtl/core/ccp_front.sv
rtl/core/ccp_queue.sv
rtl/core/ccp_back.sv
rtl/core/coefficient_compress_pack.sv
test/testbench.sv
